// ----- rtl/core/i2cee_pkg.sv -----
`default_nettype none
package i2cee_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic [1:0] REG_TWO_BYTE = 2'd0;
  localparam logic [1:0] REG_PHASE    = 2'd1;
  localparam logic [1:0] REG_TIMEOUT  = 2'd2;
  localparam logic [1:0] REG_WAIT     = 2'd3;

  localparam logic [7:0] CTRL_WRITE = 8'hA0;
  localparam logic [7:0] CTRL_READ  = 8'hA1;

  // Bus phases, one-hot.
  typedef enum logic [15:0] {
    PH_IDLE = 16'h0001, PH_S0  = 16'h0002, PH_S1  = 16'h0004, PH_S2  = 16'h0008,
    PH_TXL  = 16'h0010, PH_TXH = 16'h0020, PH_AKL = 16'h0040, PH_AKH = 16'h0080,
    PH_RXL  = 16'h0100, PH_RXH = 16'h0200, PH_NKL = 16'h0400, PH_NKH = 16'h0800,
    PH_P0   = 16'h1000, PH_P1  = 16'h2000, PH_P2  = 16'h4000, PH_WAIT = 16'h8000
  } phase_t;

  typedef enum logic [2:0] {
    STG_CTRL = 3'd0, STG_HIGH = 3'd1, STG_LOW = 3'd2,
    STG_DATA = 3'd3, STG_RCTRL = 3'd4, STG_RECV = 3'd5
  } stage_t;

  // Classified tick handed from the front to the back part.
  typedef struct packed {
    logic        start;
    logic        is_wr;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        sda;
  } tick_t;

  typedef struct packed {
    logic       scl;
    logic       pull;
    logic       busy;
    logic       done;
    logic [7:0] rbyte;
    logic       err;
  } res_t;

  typedef struct packed {
    logic        two_byte;
    logic [9:0]  phase_ticks;
    logic [7:0]  ack_timeout;
    logic [19:0] wait_ticks;
  } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/core/i2cee_front.sv -----
`default_nettype none
module i2cee_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     cmd,
  input  wire logic [15:0]    mem_address,
  input  wire logic [7:0]     write_byte,
  input  wire logic           sda_sample,
  output i2cee_pkg::tick_t    q_data,
  output logic                q_valid,
  input  wire logic           q_ready
);
  import i2cee_pkg::*;

  // Two-entry queue toward the back part.
  tick_t      mem_r [2];
  logic       wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  tick_t      cls;

  // Classify the command; code 3 acts as a plain tick.
  always_comb begin
    cls.start = (cmd == CMD_READ) || (cmd == CMD_WRITE);
    cls.is_wr = (cmd == CMD_WRITE);
    cls.addr  = mem_address;
    cls.data  = write_byte;
    cls.sda   = sda_sample;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
  end
endmodule
`default_nettype wire

// ----- rtl/core/i2cee_back.sv -----
`default_nettype none
module i2cee_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire i2cee_pkg::cfg_t  cfg,
  input  wire i2cee_pkg::tick_t q_data,
  input  wire logic             q_valid,
  output logic                  q_ready,
  output i2cee_pkg::res_t       res,
  output logic                  res_valid,
  input  wire logic             res_ready
);
  import i2cee_pkg::*;

  phase_t      ph_r, ph_nxt;
  stage_t      stg_r, stg_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [9:0]  pc_r, pc_nxt;
  logic [7:0]  poll_r, poll_nxt;
  logic [19:0] wc_r, wc_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  data_r, data_nxt;
  logic        wr_r, wr_nxt, err_r, err_nxt, done;
  logic [7:0]  hold_r, hold_nxt;
  logic [9:0]  limit, pc_inc;
  logic [7:0]  blk;
  res_t        out_r, out_nxt;
  logic        ov_r;
  logic        step;

  // Output register; a new tick is taken when the slot is free or drains.
  assign q_ready   = !ov_r || res_ready;
  assign step      = q_valid && q_ready;
  assign res       = out_r;
  assign res_valid = ov_r;

  assign limit  = (cfg.phase_ticks == 10'd0) ? 10'd1 : cfg.phase_ticks;
  assign pc_inc = pc_r + 10'd1;
  assign blk    = cfg.two_byte ? 8'd0 : {4'd0, addr_r[10:8], 1'b0};

  // Sequencer: one bus step per tick.
  always_comb begin
    ph_nxt = ph_r; stg_nxt = stg_r; bit_nxt = bit_r; sh_nxt = sh_r;
    pc_nxt = pc_r; poll_nxt = poll_r; wc_nxt = wc_r; addr_nxt = addr_r;
    data_nxt = data_r; wr_nxt = wr_r; err_nxt = err_r; hold_nxt = hold_r;
    done = 1'b0;
    case (ph_r)
      PH_IDLE: begin
        if (q_data.start) begin
          addr_nxt = q_data.addr; data_nxt = q_data.data; wr_nxt = q_data.is_wr;
          err_nxt = 1'b0; stg_nxt = STG_CTRL; bit_nxt = 4'd0; pc_nxt = 10'd0;
          poll_nxt = 8'd0; wc_nxt = 20'd0; ph_nxt = PH_S0;
        end
      end
      PH_AKH: begin
        if (!q_data.sda) begin
          pc_nxt = 10'd0;
          case (stg_r)
            STG_CTRL: begin
              bit_nxt = 4'd0; ph_nxt = PH_TXL;
              if (cfg.two_byte) begin
                stg_nxt = STG_HIGH; sh_nxt = addr_r[15:8];
              end else begin
                stg_nxt = STG_LOW; sh_nxt = addr_r[7:0];
              end
            end
            STG_HIGH: begin
              stg_nxt = STG_LOW; sh_nxt = addr_r[7:0]; bit_nxt = 4'd0; ph_nxt = PH_TXL;
            end
            STG_LOW: begin
              if (wr_r) begin
                stg_nxt = STG_DATA; sh_nxt = data_r; bit_nxt = 4'd0; ph_nxt = PH_TXL;
              end else begin
                stg_nxt = STG_RCTRL; ph_nxt = PH_S0;
              end
            end
            STG_RCTRL: begin
              stg_nxt = STG_RECV; sh_nxt = 8'd0; bit_nxt = 4'd0; ph_nxt = PH_RXL;
            end
            default: ph_nxt = PH_P0;
          endcase
        end else if (poll_r >= cfg.ack_timeout) begin
          err_nxt = 1'b1; pc_nxt = 10'd0; ph_nxt = PH_P0;
        end else begin
          poll_nxt = poll_r + 8'd1;
        end
      end
      PH_WAIT: begin
        wc_nxt = wc_r + 20'd1;
        if (wc_nxt >= cfg.wait_ticks) begin
          ph_nxt = PH_IDLE; pc_nxt = 10'd0; done = 1'b1;
        end
      end
      default: begin
        pc_nxt = pc_inc;
        if (pc_inc >= limit) begin
          pc_nxt = 10'd0;
          case (ph_r)
            PH_S0: ph_nxt = PH_S1;
            PH_S1: ph_nxt = PH_S2;
            PH_S2: begin
              sh_nxt = ((stg_r == STG_RCTRL) ? CTRL_READ : CTRL_WRITE) | blk;
              bit_nxt = 4'd0; ph_nxt = PH_TXL;
            end
            PH_TXL: ph_nxt = PH_TXH;
            PH_TXH: begin
              sh_nxt = {sh_r[6:0], 1'b0};
              if (bit_r == 4'd7) begin
                bit_nxt = 4'd0; poll_nxt = 8'd0; ph_nxt = PH_AKL;
              end else begin
                bit_nxt = bit_r + 4'd1; ph_nxt = PH_TXL;
              end
            end
            PH_AKL: ph_nxt = PH_AKH;
            PH_RXL: ph_nxt = PH_RXH;
            PH_RXH: begin
              sh_nxt = {sh_r[6:0], q_data.sda};
              if (bit_r == 4'd7) begin
                bit_nxt = 4'd0; hold_nxt = sh_nxt; ph_nxt = PH_NKL;
              end else begin
                bit_nxt = bit_r + 4'd1; ph_nxt = PH_RXL;
              end
            end
            PH_NKL: ph_nxt = PH_NKH;
            PH_NKH: ph_nxt = PH_P0;
            PH_P0:  ph_nxt = PH_P1;
            PH_P1:  ph_nxt = PH_P2;
            default: begin
              if (wr_r && !err_r && (cfg.wait_ticks != 20'd0)) begin
                wc_nxt = 20'd0; ph_nxt = PH_WAIT;
              end else begin
                ph_nxt = PH_IDLE; done = 1'b1;
              end
            end
          endcase
        end
      end
    endcase
  end

  // Bus levels decoded from the new phase.
  always_comb begin
    out_nxt.scl = 1'b1; out_nxt.pull = 1'b0;
    case (ph_nxt)
      PH_S0, PH_AKL, PH_RXL, PH_NKL: out_nxt.scl = 1'b0;
      PH_S2, PH_P1: out_nxt.pull = 1'b1;
      PH_P0: begin out_nxt.scl = 1'b0; out_nxt.pull = 1'b1; end
      PH_TXL: begin out_nxt.scl = 1'b0; out_nxt.pull = !sh_nxt[7]; end
      PH_TXH: out_nxt.pull = !sh_nxt[7];
      default: ;
    endcase
    out_nxt.busy  = (ph_nxt != PH_IDLE);
    out_nxt.done  = done;
    out_nxt.rbyte = hold_nxt;
    out_nxt.err   = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE; stg_r <= STG_CTRL; bit_r <= 4'd0; sh_r <= 8'd0;
      pc_r <= 10'd0; poll_r <= 8'd0; wc_r <= 20'd0; addr_r <= 16'd0;
      data_r <= 8'd0; wr_r <= 1'b0; err_r <= 1'b0; hold_r <= 8'd0; ov_r <= 1'b0;
    end else begin
      if (step) begin
        ph_r <= ph_nxt; stg_r <= stg_nxt; bit_r <= bit_nxt; sh_r <= sh_nxt;
        pc_r <= pc_nxt; poll_r <= poll_nxt; wc_r <= wc_nxt; addr_r <= addr_nxt;
        data_r <= data_nxt; wr_r <= wr_nxt; err_r <= err_nxt; hold_r <= hold_nxt;
      end
      if (q_ready) ov_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_r <= out_nxt;
  end
endmodule
`default_nettype wire

// ----- rtl/core/i2c_eeprom_byte_controller_top.sv -----
// Byte-level I2C master for serial EEPROMs: one-byte random read or write.
// Input stream: each request is one timebase tick with the sampled SDA level;
// a read or write command on a tick while idle starts a transaction.
// Output stream: one result per request with SCL, SDA drive, busy, done,
// the last read byte and the acknowledge error flag.
// Configuration: cfg_we writes register cfg_addr (0 two-byte address,
// 1 phase ticks, 2 ack timeout, 3 write wait ticks); the user must write
// only while the block is idle; the block does not enforce this. Requests
// pass the queue register, results the output register. Throughput: one
// request per cycle when not stalled, set by the one-step-per-tick sequencer.
// A two-entry queue separates the front from the sequencer, so a stalled
// output holds its result and the front keeps accepting until the queue fills.
// Reset (rst_n low, synchronous) returns the bus to idle: SCL high, SDA
// released, registers at their reset values, queue and output empty.
`default_nettype none
module i2c_eeprom_byte_controller_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [1:0] cmd, [17:2] mem_address, [25:18] write_byte, [26] sda_sample, zero pad
  input  wire logic [31:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] scl_level, [1] sda_pull_low, [2] busy_res, [3] done_res,
  // [11:4] read_byte, [12] ack_failed, zero pad
  output logic [15:0]      m_axis_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [19:0] cfg_wdata
);
  import i2cee_pkg::*;

  cfg_t  cfg_r;
  tick_t q_data;
  logic  q_valid, q_ready;
  res_t  res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.two_byte <= 1'b0; cfg_r.phase_ticks <= 10'd2;
      cfg_r.ack_timeout <= 8'd250; cfg_r.wait_ticks <= 20'd10000;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TWO_BYTE: cfg_r.two_byte    <= cfg_wdata[0];
        REG_PHASE:    cfg_r.phase_ticks <= cfg_wdata[9:0];
        REG_TIMEOUT:  cfg_r.ack_timeout <= cfg_wdata[7:0];
        REG_WAIT:     cfg_r.wait_ticks  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  i2cee_front u_front (
    .clk, .rst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .cmd(s_axis_tdata[1:0]), .mem_address(s_axis_tdata[17:2]),
    .write_byte(s_axis_tdata[25:18]), .sda_sample(s_axis_tdata[26]),
    .q_data, .q_valid, .q_ready
  );

  i2cee_back u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_data, .q_valid, .q_ready,
    .res, .res_valid(m_axis_tvalid), .res_ready(m_axis_tready)
  );

  assign m_axis_tdata = {3'd0, res.err, res.rbyte, res.done, res.busy, res.pull, res.scl};

`ifndef SYNTHESIS
  // Done only comes with the bus back at rest.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2] && m_axis_tdata[0])
    else $error("done without idle bus");
  // Idle bus never drives SDA.
  a_idle_release: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid && !m_axis_tdata[2] |-> !m_axis_tdata[1])
    else $error("SDA driven while idle");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
`endif
endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import i2cee_pkg::*;

  // Command code with no meaning; the block treats it as a plain tick.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = REG_TWO_BYTE;
  logic [19:0] cfg_wdata = '0;

  i2c_eeprom_byte_controller_top uut (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Result of an idle bus: SCL high, SDA released, nothing read yet.
  localparam res_t IDLE_RES = '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0};
  localparam res_t S0_RES   = '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};
  localparam res_t S1_RES   = '{1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        sda;
    logic        typed;
    res_t        res;
  } row_t;

  row_t dir_rows [6] = '{
    '{CMD_TICK,   16'h0000, 8'h00, 1'b0, 1'b1, IDLE_RES},
    '{CMD_TICK,   16'h0000, 8'h00, 1'b1, 1'b1, IDLE_RES},
    '{CMD_UNUSED, 16'hFFFF, 8'hFF, 1'b1, 1'b1, IDLE_RES},
    '{CMD_READ,   16'hFFFF, 8'hFF, 1'b0, 1'b1, S0_RES},
    '{CMD_WRITE,  16'h0000, 8'h00, 1'b0, 1'b1, S0_RES},
    '{CMD_TICK,   16'h0000, 8'h00, 1'b1, 1'b1, S1_RES}
  };

  // Bus sequencer shadow: configuration and state.
  logic        bus_two_byte = 1'b0;
  logic [9:0]  bus_phase_ticks = 10'd2;
  logic [7:0]  bus_ack_timeout = 8'd250;
  logic [19:0] bus_wait_ticks = 20'd10000;
  phase_t      bus_ph = PH_IDLE;
  stage_t      bus_stg = STG_CTRL;
  logic [3:0]  bus_bit = '0;
  logic [7:0]  bus_shift = '0;
  logic [9:0]  bus_pcnt = '0;
  logic [7:0]  bus_poll = '0;
  logic [19:0] bus_wcnt = '0;
  logic [15:0] bus_addr = '0;
  logic [7:0]  bus_data = '0;
  logic [7:0]  bus_rbyte = '0;
  logic        bus_wr = 1'b0;
  logic        bus_err = 1'b0;
  logic        bus_done = 1'b0;

  res_t        bus_results [$];
  int          errors = 0;
  int          n_requests = 0;
  int          n_results = 0;
  int          n_xfers = 0;
  int          n_done = 0;
  int          n_aborts = 0;
  bit          in_idling = 1'b0;
  bit          out_idling = 1'b0;

  function void load_byte(input logic [7:0] b);
    bus_shift = b;
    bus_bit = '0;
    bus_ph = PH_TXL;
  endfunction

  function void go_idle();
    bus_ph = PH_IDLE;
    bus_pcnt = '0;
    bus_done = 1'b1;
  endfunction

  // Address bits 10:8 ride in the control byte for small parts.
  function logic [7:0] block_bits();
    return bus_two_byte ? 8'h00 : {4'b0000, bus_addr[10:8], 1'b0};
  endfunction

  // Advances the bus sequencer by one tick and returns the levels it drives.
  function res_t bus_tick(input logic [1:0] cmd, input logic [15:0] addr,
                          input logic [7:0] data, input logic sda);
    logic [9:0] lim;
    res_t       r;
    lim = (bus_phase_ticks == 0) ? 10'd1 : bus_phase_ticks;
    bus_done = 1'b0;
    case (bus_ph)
      PH_IDLE: begin
        if (cmd == CMD_READ || cmd == CMD_WRITE) begin
          bus_addr = addr;
          bus_data = data;
          bus_wr = (cmd == CMD_WRITE);
          bus_err = 1'b0;
          bus_stg = STG_CTRL;
          bus_bit = '0;
          bus_pcnt = '0;
          bus_poll = '0;
          bus_wcnt = '0;
          bus_ph = PH_S0;
        end
      end
      PH_AKH: begin
        if (!sda) begin
          // Acknowledge seen: move on to the next byte of the sequence.
          bus_pcnt = '0;
          case (bus_stg)
            STG_CTRL: begin
              if (bus_two_byte) begin
                bus_stg = STG_HIGH;
                load_byte(bus_addr[15:8]);
              end else begin
                bus_stg = STG_LOW;
                load_byte(bus_addr[7:0]);
              end
            end
            STG_HIGH: begin
              bus_stg = STG_LOW;
              load_byte(bus_addr[7:0]);
            end
            STG_LOW: begin
              if (bus_wr) begin
                bus_stg = STG_DATA;
                load_byte(bus_data);
              end else begin
                bus_stg = STG_RCTRL;
                bus_ph = PH_S0;
              end
            end
            STG_RCTRL: begin
              bus_stg = STG_RECV;
              bus_shift = '0;
              bus_bit = '0;
              bus_ph = PH_RXL;
            end
            default: bus_ph = PH_P0;
          endcase
        end else if (bus_poll >= bus_ack_timeout) begin
          bus_err = 1'b1;
          bus_pcnt = '0;
          bus_ph = PH_P0;
        end else begin
          bus_poll++;
        end
      end
      PH_WAIT: begin
        bus_wcnt++;
        if (bus_wcnt >= bus_wait_ticks) go_idle();
      end
      default: begin
        bus_pcnt++;
        if (bus_pcnt >= lim) begin
          bus_pcnt = '0;
          case (bus_ph)
            PH_S0: bus_ph = PH_S1;
            PH_S1: bus_ph = PH_S2;
            PH_S2: load_byte((bus_stg == STG_RCTRL ? CTRL_READ : CTRL_WRITE) | block_bits());
            PH_TXL: bus_ph = PH_TXH;
            PH_TXH: begin
              bus_shift = {bus_shift[6:0], 1'b0};
              bus_bit++;
              if (bus_bit >= 8) begin
                bus_bit = '0;
                bus_poll = '0;
                bus_ph = PH_AKL;
              end else begin
                bus_ph = PH_TXL;
              end
            end
            PH_AKL: bus_ph = PH_AKH;
            PH_RXL: bus_ph = PH_RXH;
            PH_RXH: begin
              bus_shift = {bus_shift[6:0], sda};
              bus_bit++;
              if (bus_bit >= 8) begin
                bus_bit = '0;
                bus_rbyte = bus_shift;
                bus_ph = PH_NKL;
              end else begin
                bus_ph = PH_RXL;
              end
            end
            PH_NKL: bus_ph = PH_NKH;
            PH_NKH: bus_ph = PH_P0;
            PH_P0: bus_ph = PH_P1;
            PH_P1: bus_ph = PH_P2;
            PH_P2: begin
              if (bus_wr && !bus_err && bus_wait_ticks != 0) begin
                bus_wcnt = '0;
                bus_ph = PH_WAIT;
              end else begin
                go_idle();
              end
            end
            default: go_idle();
          endcase
        end
      end
    endcase
    // Line levels for the new phase.
    case (bus_ph)
      PH_S0, PH_AKL, PH_RXL, PH_NKL: begin r.scl = 1'b0; r.pull = 1'b0; end
      PH_S2, PH_P1:                  begin r.scl = 1'b1; r.pull = 1'b1; end
      PH_P0:                         begin r.scl = 1'b0; r.pull = 1'b1; end
      PH_TXL:                        begin r.scl = 1'b0; r.pull = ~bus_shift[7]; end
      PH_TXH:                        begin r.scl = 1'b1; r.pull = ~bus_shift[7]; end
      default:                       begin r.scl = 1'b1; r.pull = 1'b0; end
    endcase
    r.busy = (bus_ph != PH_IDLE);
    r.done = bus_done;
    r.rbyte = bus_rbyte;
    r.err = bus_err;
    return r;
  endfunction

  task report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH result %0d %s: got %0h expected %0h", n_results, what, got, want);
    errors++;
  endtask

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Sends one request; a typed expectation overrides the predicted one.
  task send_request(input logic [1:0] cmd, input logic [15:0] addr, input logic [7:0] data,
                    input logic sda, input logic typed = 1'b0, input res_t want = IDLE_RES);
    int   gap;
    res_t pred;
    gap = in_idling ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, sda, data, addr, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pred = bus_tick(cmd, addr, data, sda);
    bus_results.push_back(typed ? want : pred);
    n_requests++;
  endtask

  // Ticks until the sequencer is idle again; the slave acks or stays silent.
  task finish_transfer(input bit silent);
    logic sda;
    logic [1:0] cmd;
    while (bus_ph != PH_IDLE) begin
      if (bus_ph == PH_AKH) sda = silent ? 1'b1 : ($urandom_range(0, 3) == 0);
      else sda = $urandom_range(0, 1);
      cmd = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(1, 3)) : CMD_TICK;
      send_request(cmd, 16'($urandom), 8'($urandom), sda);
    end
    if (bus_err) n_aborts++;
    n_xfers++;
  endtask

  task run_transfer(input logic [1:0] cmd, input logic [15:0] addr, input logic [7:0] data,
                    input bit silent);
    send_request(cmd, addr, data, 1'($urandom));
    finish_transfer(silent);
  endtask

  // Register writes happen only with the block drained and idle.
  task write_reg(input logic [1:0] idx, input logic [19:0] val);
    s_axis_tvalid <= 1'b0;
    wait (bus_results.size() == 0);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TWO_BYTE: bus_two_byte = val[0];
      REG_PHASE:    bus_phase_ticks = val[9:0];
      REG_TIMEOUT:  bus_ack_timeout = val[7:0];
      default:      bus_wait_ticks = val;
    endcase
  endtask

  task write_all(input logic two, input logic [9:0] ph, input logic [7:0] tmo,
                 input logic [19:0] wt);
    write_reg(REG_TWO_BYTE, {19'b0, two});
    write_reg(REG_PHASE, {10'b0, ph});
    write_reg(REG_TIMEOUT, {12'b0, tmo});
    write_reg(REG_WAIT, wt);
  endtask

  // Result side: random stalls, with stretches of none.
  initial begin
    int g;
    forever begin
      if ($urandom_range(0, 49) == 0) out_idling = $urandom_range(0, 2) != 0;
      g = out_idling ? $urandom_range(0, 13) : 0;
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (bus_results.size() == 0) begin
        $display("MISMATCH result %0d arrived with nothing expected", n_results);
        errors++;
      end else begin
        want = bus_results.pop_front();
        if (m_axis_tdata[0] !== want.scl) report_mismatch("scl", m_axis_tdata[0], want.scl);
        if (m_axis_tdata[1] !== want.pull) report_mismatch("sda_pull", m_axis_tdata[1], want.pull);
        if (m_axis_tdata[2] !== want.busy) report_mismatch("busy", m_axis_tdata[2], want.busy);
        if (m_axis_tdata[3] !== want.done) report_mismatch("done", m_axis_tdata[3], want.done);
        if (m_axis_tdata[11:4] !== want.rbyte)
          report_mismatch("read_byte", m_axis_tdata[11:4], want.rbyte);
        if (m_axis_tdata[12] !== want.err) report_mismatch("ack_failed", m_axis_tdata[12], want.err);
        if (want.done) n_done++;
      end
    end
  end

  // Watchdog.
  initial begin
    #50000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Main stimulus.
  initial begin
    int r;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows straight after reset.
    foreach (dir_rows[i])
      send_request(dir_rows[i].cmd, dir_rows[i].addr, dir_rows[i].data, dir_rows[i].sda,
                   dir_rows[i].typed, dir_rows[i].res);
    finish_transfer(1'b0);

    // Zero phase, zero timeout, zero write wait.
    write_all(1'b0, 10'd0, 8'd0, 20'd0);
    run_transfer(CMD_WRITE, 16'hFFFF, 8'h00, 1'b0);
    run_transfer(CMD_READ, 16'h0000, 8'hFF, 1'b1);
    // Large parts, longest ack timeout, short write wait.
    write_all(1'b1, 10'd1, 8'd255, 20'd5);
    run_transfer(CMD_WRITE, 16'hFFFF, 8'hFF, 1'b0);
    run_transfer(CMD_READ, 16'h8000, 8'h55, 1'b1);
    run_transfer(CMD_READ, 16'h7FFF, 8'hAA, 1'b0);
    // Largest phase and write wait, with the bus left idle.
    write_all(1'b0, 10'd1023, 8'd1, 20'hFFFFF);
    repeat (4) send_request(CMD_UNUSED, 16'($urandom), 8'($urandom), 1'($urandom));

    write_all(1'b0, 10'd1, 8'd3, 20'd8);
    while (n_requests < 1700) begin
      in_idling = $urandom_range(0, 3) != 0;
      r = $urandom_range(0, 9);
      if (r == 0) begin
        write_all(1'($urandom), 10'($urandom_range(0, 3)),
                  ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6)),
                  20'($urandom_range(0, 30)));
      end else if (r <= 7) begin
        run_transfer(CMD_READ + 2'($urandom_range(0, 1)), 16'($urandom), 8'($urandom),
                     $urandom_range(0, 7) == 0);
      end else begin
        repeat ($urandom_range(1, 5))
          send_request($urandom_range(0, 1) ? CMD_TICK : CMD_UNUSED, 16'($urandom),
                       8'($urandom), 1'($urandom));
      end
    end

    s_axis_tvalid <= 1'b0;
    wait (bus_results.size() == 0);
    repeat (10) @(posedge clk);
    $display("Covered %0d tick requests, %0d results, %0d transfers (%0d aborted).",
             n_requests, n_results, n_xfers, n_aborts);
    $display("Done pulses seen: %0d, mismatches: %0d.", n_done, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
